### hw/rtl/vt_pkg.sv
// shared types and constants for the value table core
// no dependencies; used by vt_ctrl, vt_dp and the top level
package vt_pkg;

	localparam int CAPACITY_DEF = 128;
	localparam int DATA_W       = 32;
	localparam int MODE_W       = 2;
	localparam int STATUS_W     = 2;
	localparam int POS_W        = 7;
	localparam int COUNT_W      = 8;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_SEARCH = 2'd2
	} vt_mode_e;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} vt_status_e;

	typedef enum logic [1:0] {
		POS_ZERO  = 2'd0,
		POS_HIT   = 2'd1,
		POS_COUNT = 2'd2
	} vt_pos_sel_e;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_SCAN  = 2'd1,
		ST_SHIFT = 2'd2,
		ST_DONE  = 2'd3
	} vt_state_e;

	typedef struct packed {
		logic        accept;
		logic        ins_write;
		logic        cnt_inc;
		logic        cnt_dec;
		logic        rd_issue;
		logic        shift_wr;
		logic        res_set;
		vt_status_e  res_status;
		vt_pos_sel_e res_pos;
		logic        load_out;
	} vt_cmd_t;

	typedef struct packed {
		logic full;
		logic hit;
		logic exhausted;
	} vt_stat_t;

endpackage

### hw/rtl/vt_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module vt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/vt_dp.sv
// datapath: entry ram, count, scan index, compare and result registers
// depends on vt_pkg and vt_ram
module vt_dp #(
	parameter int CAPACITY = vt_pkg::CAPACITY_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  vt_pkg::vt_cmd_t              cmd,
	output vt_pkg::vt_stat_t             stat,
	input  logic [vt_pkg::DATA_W-1:0]    value,
	output vt_pkg::vt_status_e           out_status,
	output logic [vt_pkg::POS_W-1:0]     out_pos,
	output logic [vt_pkg::COUNT_W-1:0]   out_count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	logic [CW-1:0]             count_q;
	logic [CW-1:0]             idx_q;
	logic [vt_pkg::DATA_W-1:0] key_q;
	logic                      rvalid_s1;
	logic [IW-1:0]             ridx_s1;
	logic [vt_pkg::DATA_W-1:0] rdata;
	vt_pkg::vt_status_e        res_status_q;
	logic [IW-1:0]             res_pos_q;
	logic                      issue;
	logic                      we;
	logic [IW-1:0]             waddr;
	logic [vt_pkg::DATA_W-1:0] wdata;

	assign issue = cmd.rd_issue && (idx_q < count_q);

	assign we    = cmd.ins_write || (cmd.shift_wr && rvalid_s1);
	assign waddr = cmd.ins_write ? count_q[IW-1:0] : ridx_s1 - IW'(1);
	assign wdata = cmd.ins_write ? value : rdata;

	assign stat.full      = (count_q == CW'(CAPACITY));
	assign stat.hit       = rvalid_s1 && (rdata == key_q);
	assign stat.exhausted = !rvalid_s1 && (idx_q >= count_q);

	vt_ram #(
		.WIDTH (vt_pkg::DATA_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (idx_q[IW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			rvalid_s1 <= cmd.accept ? 1'b0 : issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q <= value;
			idx_q <= '0;
		end else if (issue) begin
			idx_q <= idx_q + CW'(1);
		end
		if (issue) begin
			ridx_s1 <= idx_q[IW-1:0];
		end
		if (cmd.res_set) begin
			res_status_q <= cmd.res_status;
			unique case (cmd.res_pos)
				vt_pkg::POS_HIT:   res_pos_q <= ridx_s1;
				vt_pkg::POS_COUNT: res_pos_q <= count_q[IW-1:0];
				default:           res_pos_q <= '0;
			endcase
		end
		if (cmd.load_out) begin
			out_status <= res_status_q;
			out_pos    <= vt_pkg::POS_W'(res_pos_q);
			out_count  <= vt_pkg::COUNT_W'(count_q);
		end
	end

endmodule

### hw/rtl/vt_ctrl.sv
// controller state machine: sequences insert, scan and shift, owns handshakes
// depends on vt_pkg
module vt_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [vt_pkg::MODE_W-1:0]  in_mode,
	output logic                       out_valid,
	input  logic                       out_ready,
	input  vt_pkg::vt_stat_t           stat,
	output vt_pkg::vt_cmd_t            cmd
);

	vt_pkg::vt_state_e state_q, state_d;
	vt_pkg::vt_mode_e  mode_q;
	logic              out_valid_q;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vt_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q <= vt_pkg::vt_mode_e'(in_mode);
		end
	end

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		cmd            = '0;
		cmd.res_status = vt_pkg::ST_OK;
		cmd.res_pos    = vt_pkg::POS_ZERO;
		unique case (state_q)
			vt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					unique case (in_mode)
						vt_pkg::MODE_INSERT: begin
							cmd.res_set = 1'b1;
							if (stat.full) begin
								cmd.res_status = vt_pkg::ST_FULL;
							end else begin
								cmd.ins_write = 1'b1;
								cmd.cnt_inc   = 1'b1;
								cmd.res_pos   = vt_pkg::POS_COUNT;
							end
							state_d = vt_pkg::ST_DONE;
						end
						vt_pkg::MODE_DELETE,
						vt_pkg::MODE_SEARCH: begin
							state_d = vt_pkg::ST_SCAN;
						end
						default: begin
							// unused mode: report ok, leave the table alone
							cmd.res_set = 1'b1;
							state_d     = vt_pkg::ST_DONE;
						end
					endcase
				end
			end
			vt_pkg::ST_SCAN: begin
				cmd.rd_issue = 1'b1;
				if (stat.hit) begin
					cmd.res_set = 1'b1;
					cmd.res_pos = vt_pkg::POS_HIT;
					state_d = (mode_q == vt_pkg::MODE_DELETE) ? vt_pkg::ST_SHIFT
						: vt_pkg::ST_DONE;
				end else if (stat.exhausted) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = vt_pkg::ST_MISSING;
					state_d        = vt_pkg::ST_DONE;
				end
			end
			vt_pkg::ST_SHIFT: begin
				cmd.rd_issue = 1'b1;
				cmd.shift_wr = 1'b1;
				if (stat.exhausted) begin
					cmd.cnt_dec = 1'b1;
					state_d     = vt_pkg::ST_DONE;
				end
			end
			vt_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = vt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/value_table_insert_delete_search_core.sv
// value table core: unsorted list of signed 32-bit words with insert, delete, search
// insert or unused mode goes straight to the result; search scans until a hit or the
// end of the table; delete scans, then on a hit shifts the later entries down one place
// one request in flight, next word taken the cycle after the result loads
// a waiting result holds back only the next result
// reset clears the count and handshake state only; entry ram contents are not cleared
module value_table_insert_delete_search_core #(
	parameter int CAPACITY = vt_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request word
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] value
	input  logic [1:0]  s_axis_tuser,  // [1:0] mode
	// result word
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [6:0] position, [14:7] entry_count, [15] zero
	output logic [1:0]  m_axis_tuser   // [1:0] status
);

	vt_pkg::vt_cmd_t                 cmd;
	vt_pkg::vt_stat_t                stat;
	vt_pkg::vt_status_e              out_status;
	logic [vt_pkg::POS_W-1:0]        out_pos;
	logic [vt_pkg::COUNT_W-1:0]      out_count;

	// controller: walks idle, scan, shift and result hand-off
	vt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_mode   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: entry storage, count and the result word register
	vt_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.value      (s_axis_tdata),
		.out_status (out_status),
		.out_pos    (out_pos),
		.out_count  (out_count)
	);

	// pack result word, position lowest
	assign m_axis_tdata = {1'b0, out_count, out_pos};
	assign m_axis_tuser = out_status;

endmodule
